// ===== rtl/core/cia_pkg.sv =====
// Package for the checked 32-bit ALU: opcodes, error codes, transaction types.
// Also holds the one-bit restoring divide step used by the back-end pipeline.
// No dependencies.
package cia_pkg;

    localparam int DIV_STAGES = 32;
    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = $clog2(Q_DEPTH);

    typedef enum logic [2:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_SHL = 3'd4,
        CMD_SHR = 3'd5,
        CMD_MOD = 3'd6
    } cmd_e;

    typedef enum logic [1:0] {
        ERR_OK       = 2'd0,
        ERR_OVF      = 2'd1,
        ERR_ZERO     = 2'd2,
        ERR_NEGSHIFT = 2'd3
    } err_e;

    typedef struct packed {
        logic [2:0]  kind;
        err_e        err;
        logic [31:0] res;
        logic        neg_q;
        logic        neg_r;
        logic [31:0] mag_a;
        logic [31:0] mag_b;
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] rem;
        logic [31:0] quo;
    } stage_t;

    function automatic stage_t div_step(input stage_t s);
        stage_t      t;
        logic [32:0] r;
        t = s;
        r = {s.rem, s.quo[31]};
        t.quo = {s.quo[30:0], 1'b0};
        if (r >= {1'b0, s.op.mag_b})
        begin
            r = r - {1'b0, s.op.mag_b};
            t.quo[0] = 1'b1;
        end
        t.rem = r[31:0];
        return t;
    endfunction

endpackage

// ===== rtl/core/cia_front.sv =====
// Front end: accepts transactions, checks operands, resolves add/sub/shift.
// Multiply and divide are prepared as magnitudes and signs. Uses cia_pkg.
module cia_front
    import cia_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  cmd,
    input  logic [31:0] operand_a,
    input  logic [31:0] operand_b,
    output logic        op_valid,
    input  logic        op_ready,
    output op_t         op
);

    logic        valid_reg;
    op_t         op_reg;
    op_t         op_next;
    logic [32:0] sum;
    logic [32:0] diff;
    logic        b_big;
    logic [4:0]  shr_n;

    assign in_ready = !valid_reg || op_ready;
    assign op_valid = valid_reg;
    assign op       = op_reg;

    always_comb
    begin
        sum   = {operand_a[31], operand_a} + {operand_b[31], operand_b};
        diff  = {operand_a[31], operand_a} - {operand_b[31], operand_b};
        b_big = (|operand_b[30:5]) || (operand_b[4:0] == 5'd31);
        shr_n = b_big ? 5'd31 : operand_b[4:0];

        op_next.kind  = cmd;
        op_next.err   = ERR_OK;
        op_next.res   = '0;
        op_next.neg_q = operand_a[31] ^ operand_b[31];
        op_next.neg_r = operand_a[31];
        op_next.mag_a = operand_a[31] ? (~operand_a + 32'd1) : operand_a;
        op_next.mag_b = operand_b[31] ? (~operand_b + 32'd1) : operand_b;

        case (cmd)
            CMD_ADD:
            begin
                if (sum[32] != sum[31])
                    op_next.err = ERR_OVF;
                op_next.res = sum[31:0];
            end
            CMD_SUB:
            begin
                if (diff[32] != diff[31])
                    op_next.err = ERR_OVF;
                op_next.res = diff[31:0];
            end
            CMD_SHL:
            begin
                if (operand_b[31])
                    op_next.err = ERR_NEGSHIFT;
                else if (b_big)
                begin
                    if (operand_a != '0)
                        op_next.err = ERR_OVF;
                end
                else if ((op_next.mag_a >> (5'd31 - operand_b[4:0])) != '0)
                    op_next.err = ERR_OVF;
                op_next.res = operand_a << operand_b[4:0];
            end
            CMD_SHR:
            begin
                if (operand_b[31])
                    op_next.err = ERR_NEGSHIFT;
                op_next.res = $unsigned($signed(operand_a) >>> shr_n);
            end
            CMD_DIV:
            begin
                if (operand_b == '0)
                    op_next.err = ERR_ZERO;
                else if (operand_a == 32'h8000_0000 && operand_b == 32'hFFFF_FFFF)
                    op_next.err = ERR_OVF;
            end
            CMD_MOD:
            begin
                if (operand_b == '0)
                    op_next.err = ERR_ZERO;
            end
            default:
            begin
                op_next.res = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            op_reg <= op_next;
    end

endmodule

// ===== rtl/core/cia_queue.sv =====
// Short FIFO between front and back end so each side stalls on its own.
// Depth from cia_pkg::Q_DEPTH.
module cia_queue
    import cia_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  op_t  push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output op_t  pop_data
);

    op_t             mem [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_AW:0]   count_reg;
    logic            push;
    logic            pop;

    assign push_ready = (count_reg != Q_DEPTH[Q_AW:0]);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== rtl/core/cia_back.sv =====
// Back end: 32-stage restoring divider pipeline that also carries the other ops,
// a multiplier in the first stage with the overflow check in the second, output register.
// Uses cia_pkg.
module cia_back
    import cia_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        op_valid,
    output logic        op_ready,
    input  op_t         op,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] value,
    output logic [1:0]  error_code
);

    stage_t      st_reg [DIV_STAGES];
    stage_t      st_next [DIV_STAGES];
    logic        v_reg [DIV_STAGES];
    logic [63:0] prod_reg;
    logic        out_valid_reg;
    logic [31:0] value_reg;
    logic [1:0]  error_reg;
    logic [31:0] value_next;
    logic        en;
    stage_t      init;
    stage_t      fold;
    stage_t      last;

    assign en         = !out_valid_reg || out_ready;
    assign op_ready   = en;
    assign out_valid  = out_valid_reg;
    assign value      = value_reg;
    assign error_code = error_reg;

    always_comb
    begin
        init.op  = op;
        init.rem = '0;
        init.quo = op.mag_a;
        fold = div_step(st_reg[0]);
        if (st_reg[0].op.kind == CMD_MUL)
        begin
            if (prod_reg > 64'h0000_0000_7FFF_FFFF)
                fold.op.err = ERR_OVF;
            else
                fold.op.res = st_reg[0].op.neg_q ? (~prod_reg[31:0] + 32'd1) : prod_reg[31:0];
        end
    end

    genvar i;
    generate
        for (i = 0; i < DIV_STAGES; i++)
        begin : g_stage
            if (i == 0)
            begin : g_first
                assign st_next[i] = div_step(init);
            end
            else if (i == 1)
            begin : g_mul
                assign st_next[i] = fold;
            end
            else
            begin : g_div
                assign st_next[i] = div_step(st_reg[i-1]);
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[i] <= 1'b0;
                else if (en)
                    v_reg[i] <= (i == 0) ? op_valid : v_reg[(i == 0) ? 0 : i-1];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                    st_reg[i] <= st_next[i];
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
            prod_reg <= 64'(op.mag_a) * 64'(op.mag_b);
    end

    always_comb
    begin
        last = st_reg[DIV_STAGES-1];
        case (last.op.kind)
            CMD_DIV:
                value_next = last.op.neg_q ? (~last.quo + 32'd1) : last.quo;
            CMD_MOD:
                value_next = last.op.neg_r ? (~last.rem + 32'd1) : last.rem;
            default:
                value_next = last.op.res;
        endcase
        if (last.op.err != ERR_OK)
            value_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= v_reg[DIV_STAGES-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            value_reg <= value_next;
            error_reg <= last.op.err;
        end
    end

endmodule

// ===== rtl/core/checked_integer_alu.sv =====
// Checked 32-bit signed ALU: add, sub, mul, div, shl, shr, mod with error codes.
// Path with no stall: front register, queue, 32 divider stages, output register.
// Throughput one transaction per cycle while out_ready does not stall the output, set by the fully pipelined divider.
// Reset (rst_n, async, active low) empties all stages and the queue; no state kept.
// Depends on cia_pkg, cia_front, cia_queue, cia_back.
module checked_integer_alu
    import cia_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  cmd,
    input  logic [31:0] operand_a,
    input  logic [31:0] operand_b,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] value,
    output logic [1:0]  error_code
);

    logic f_valid;
    logic f_ready;
    op_t  f_op;
    logic q_valid;
    logic q_ready;
    op_t  q_op;

    cia_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .op_valid  (f_valid),
        .op_ready  (f_ready),
        .op        (f_op)
    );

    cia_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_op),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_op)
    );

    cia_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .op_valid   (q_valid),
        .op_ready   (q_ready),
        .op         (q_op),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .value      (value),
        .error_code (error_code)
    );

endmodule

// ===== rtl/core/cia_checker.sv =====
// Port-level checker for checked_integer_alu, bound to the top level.
// Uses cia_pkg error codes.
module cia_checker
    import cia_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] value,
    input logic [1:0]  error_code
);

    logic [6:0] pend_reg;
    logic       acc_in;
    logic       acc_out;

    assign acc_in  = in_valid && in_ready;
    assign acc_out = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else if (acc_in && !acc_out)
            pend_reg <= pend_reg + 1'b1;
        else if (acc_out && !acc_in)
            pend_reg <= pend_reg - 1'b1;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value) && $stable(error_code))
        else $error("result changed while stalled");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code != ERR_OK |-> value == '0)
        else $error("nonzero value with error");

    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != '0)
        else $error("result without pending transaction");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg < 7'd40)
        else $error("too many transactions in flight");

endmodule

bind checked_integer_alu cia_checker u_cia_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value      (value),
    .error_code (error_code)
);

// ===== tb/tb_checked_integer_alu.sv =====
// Testbench for checked_integer_alu: directed corner operations, then random traffic.
// A scoreboard class predicts value and error code per transaction and checks results.
// Depends on cia_pkg and the checked_integer_alu RTL.
module tb_checked_integer_alu;
    import cia_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] value;
        err_e        err;
    } alu_result_t;

    function automatic alu_result_t compute_alu(logic [2:0] op, logic [31:0] ra, logic [31:0] rb);
        alu_result_t    o;
        longint         a;
        longint         b;
        longint         r;
        longint unsigned ma;
        longint unsigned mb;
        logic [31:0]    sh;
        a = longint'(signed'(ra));
        b = longint'(signed'(rb));
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        r = 0;
        o.err = ERR_OK;
        case (op)
            CMD_ADD:
            begin
                r = a + b;
                if (r > 64'sd2147483647 || r < -64'sd2147483648) o.err = ERR_OVF;
            end
            CMD_SUB:
            begin
                r = a - b;
                if (r > 64'sd2147483647 || r < -64'sd2147483648) o.err = ERR_OVF;
            end
            CMD_MUL:
            begin
                if (a != 0 && b != 0 && ma * mb > 64'd2147483647) o.err = ERR_OVF;
                else r = a * b;
            end
            CMD_DIV:
            begin
                if (b == 0) o.err = ERR_ZERO;
                else if (a == -64'sd2147483648 && b == -1) o.err = ERR_OVF;
                else r = a / b;
            end
            CMD_SHL:
            begin
                if (b < 0) o.err = ERR_NEGSHIFT;
                else if (b >= 31)
                begin
                    if (a != 0) o.err = ERR_OVF;
                end
                else if ((ma >> (31 - b)) != 0) o.err = ERR_OVF;
                else
                begin
                    sh = ra << b;
                    r = longint'(signed'(sh));
                end
            end
            CMD_SHR:
            begin
                if (b < 0) o.err = ERR_NEGSHIFT;
                else
                begin
                    sh = signed'(ra) >>> ((b >= 31) ? 31 : b);
                    r = longint'(signed'(sh));
                end
            end
            CMD_MOD:
            begin
                if (b == 0) o.err = ERR_ZERO;
                else r = a % b;
            end
            default: r = 0;
        endcase
        if (o.err != ERR_OK) r = 0;
        o.value = r[31:0];
        return o;
    endfunction

    class alu_scoreboard;
        alu_result_t pending[$];
        int          errors = 0;
        int          checked = 0;

        function void note_input(logic [2:0] op, logic [31:0] a, logic [31:0] b);
            pending.push_back(compute_alu(op, a, b));
        endfunction

        function void check_result(logic [31:0] v, logic [1:0] e);
            alu_result_t want;
            if (pending.size() == 0)
            begin
                $display("%0t unexpected transaction value=%h err=%0d", $time, v, e);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (v !== want.value)
            begin
                $display("%0t value mismatch expected %h actual %h", $time, want.value, v);
                errors++;
            end
            if (e !== want.err)
            begin
                $display("%0t error_code mismatch expected %0d actual %0d", $time, want.err, e);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_ready;
    logic [2:0]  cmd = '0;
    logic [31:0] operand_a = '0;
    logic [31:0] operand_b = '0;
    logic        out_valid;
    logic        out_ready = 0;
    logic [31:0] value;
    logic [1:0]  error_code;

    alu_scoreboard sb = new();
    int  send_idle_pct = 32;
    int  recv_idle_pct = 49;
    bit  hold_off = 0;
    bit  sending_done = 0;
    int  sent = 0;

    always #6 clk = ~clk;

    checked_integer_alu dut (.*);

    always @(posedge clk)
    begin
        if (in_valid && in_ready) sb.note_input(cmd, operand_a, operand_b);
        if (out_valid && out_ready) sb.check_result(value, error_code);
    end

    always @(posedge clk)
    begin
        if (!rst_n) out_ready <= 0;
        else out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_op(logic [2:0] op, logic [31:0] a, logic [31:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        cmd <= op;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent++;
    endtask

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(40);
            3: return -$urandom_range(40);
            4: return $urandom_range(65535);
            5: return -$urandom_range(65535);
            default: return $urandom;
        endcase
    endfunction

    localparam logic [31:0] MINV = 32'h8000_0000;
    localparam logic [31:0] MAXV = 32'h7fff_ffff;
    localparam logic [31:0] NEG1 = 32'hffff_ffff;

    initial
    begin
        logic [2:0] op;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        send_op(CMD_ADD, MAXV, 1);
        send_op(CMD_ADD, MINV, NEG1);
        send_op(CMD_SUB, MINV, 1);
        send_op(CMD_SUB, 0, MINV);
        send_op(CMD_MUL, 32'h0001_0000, 32'h0000_8000);
        send_op(CMD_MUL, MINV, 1);
        send_op(CMD_MUL, 0, MINV);
        send_op(CMD_MUL, NEG1, MAXV);
        send_op(CMD_DIV, 5, 0);
        send_op(CMD_DIV, MINV, NEG1);
        send_op(CMD_DIV, -7, 2);
        send_op(CMD_MOD, MINV, NEG1);
        send_op(CMD_MOD, 7, 0);
        send_op(CMD_MOD, -7, 2);
        send_op(CMD_SHL, 1, NEG1);
        send_op(CMD_SHL, 1, 30);
        send_op(CMD_SHL, 1, 31);
        send_op(CMD_SHL, 0, 40);
        send_op(CMD_SHL, -1, 31);
        send_op(CMD_SHR, MINV, 31);
        send_op(CMD_SHR, MINV, MAXV);
        send_op(CMD_SHR, MAXV, 100);
        send_op(CMD_SHR, 5, MINV);
        send_op(3'd7, MAXV, MAXV);
        for (int i = 0; i < 1500; i++)
        begin
            if (i == 500)
            begin
                send_idle_pct = 49;
                recv_idle_pct = 32;
            end
            if (i == 1000)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            op = ($urandom_range(49) == 0) ? 3'd7 : 3'($urandom_range(6));
            send_op(op, pick_operand(), pick_operand());
        end
        in_valid <= 0;
        sending_done = 1;
    end

    // Long receiver stall during the idle-free phase to back up the pipeline
    initial
    begin
        wait (sent >= 1100);
        @(posedge clk);
        hold_off = 1;
        repeat (200) @(posedge clk);
        hold_off = 0;
    end

    initial
    begin
        wait (sending_done);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        $display("Ran %0d transactions over all seven operations and opcode 7,", sent);
        $display("%0d results checked, including overflow, zero divide and shift corners.",
                 sb.checked);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("Timeout with %0d results outstanding", sb.pending.size());
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
